// ----- src/bwv_pkg.sv -----
// Breit-Wigner variate transform: shared types, widths and constants.
// Holds the arctangent table for the CORDIC cells; no dependencies.
package bwv_pkg;

   localparam int ANG_W      = 44;
   localparam int VEC_W      = 60;
   localparam int RAD_W      = 42;
   localparam int MAG_W      = 58;
   localparam int DIV_W      = 93;
   localparam int QUOT_BITS  = 66;
   localparam int PIPE_EXTRA = 79;
   localparam int ATAN_DEPTH = 64;

   localparam logic [63:0] PI_Q60      = 64'h3243_F6A8_885A_308D;
   localparam logic [47:0] MAX48       = 48'hFFFF_FFFF_FFFF;
   localparam logic [31:0] MASS_RESET  = 32'h0050_0000;
   localparam logic [31:0] WIDTH_RESET = 32'h0002_0000;

   localparam logic [0:0] CSR_PEAK_MASS  = 1'b0;
   localparam logic [0:0] CSR_PEAK_WIDTH = 1'b1;

   typedef logic signed [ANG_W-1:0] angle_type;
   typedef logic signed [VEC_W-1:0] vec_type;
   typedef angle_type atan_table_type [0:ATAN_DEPTH-1];

   typedef struct packed {
      vec_type   x;
      vec_type   y;
      angle_type z;
   } cordic_vec_type;

   typedef struct packed {
      logic [DIV_W-1:0]     rem;
      logic [DIV_W-1:0]     dvs;
      logic [QUOT_BITS-1:0] nlo;
      logic [QUOT_BITS-1:0] quot;
   } div_lane_type;

   typedef div_lane_type [1:0] div_pair_type;

   typedef struct packed {
      logic        pole;
      logic        neg;
      logic        sat_tan;
      logic        sat_sec;
      logic [63:0] m2;
      logic [63:0] w;
   } tail_side_type;

   function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
      logic [63:0] quo;
      logic [63:0] rem;
      int          b;
      quo = '0;
      rem = '0;
      for (b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic atan_table_type atan_table_calc();
      atan_table_type tbl;
      longint         sum;
      longint         term;
      int             e;
      int             i;
      int             k;
      for (i = 0; i < ATAN_DEPTH; i++) begin
         sum = 0;
         if (i == 0) begin
            sum = longint'(PI_Q60 >> 2);
         end else begin
            for (k = 0; k < 31; k++) begin
               e = i * (2 * k + 1);
               if (e <= 60) begin
                  term = longint'(div_u64(64'd1 << (60 - e), 64'(2 * k + 1)));
                  sum = ((k & 1) == 1) ? sum - term : sum + term;
               end
            end
         end
         tbl[i] = angle_type'((sum + 64'sd524288) >>> 20);
      end
      return tbl;
   endfunction

   localparam atan_table_type ATAN_Q40 = atan_table_calc();
   localparam angle_type HALF_PI_Q40 = angle_type'((PI_Q60 + 64'd1048576) >> 21);
   localparam vec_type POLE_LIMIT = vec_type'(4096);
   localparam vec_type ROT_X0 = vec_type'(64'd1 << 57);

endpackage

// ----- src/bwv_mul.sv -----
// Two-stage 64x64 unsigned multiplier built from four 32x32 partial products.
// Depends on nothing.
module bwv_mul (
   input  logic          clock,
   input  logic [63:0]   mul_a,
   input  logic [63:0]   mul_b,
   output logic [127:0]  product
);

   logic [63:0]  pp_ff [4];
   logic [63:0]  pp_in [4];
   logic [127:0] product_ff;
   logic [127:0] product_in;

   always_comb begin
      pp_in[0] = 64'(mul_a[31:0])  * 64'(mul_b[31:0]);
      pp_in[1] = 64'(mul_a[31:0])  * 64'(mul_b[63:32]);
      pp_in[2] = 64'(mul_a[63:32]) * 64'(mul_b[31:0]);
      pp_in[3] = 64'(mul_a[63:32]) * 64'(mul_b[63:32]);
      product_in = {64'd0, pp_ff[0]} + {32'd0, pp_ff[1], 32'd0}
                 + {32'd0, pp_ff[2], 32'd0} + {pp_ff[3], 64'd0};
   end

   always_ff @(posedge clock) begin
      pp_ff      <= pp_in;
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

// ----- src/bwv_cordic_cell.sv -----
// One CORDIC micro-rotation stage, vectoring or rotation, with a pass-along side word.
// Depends on bwv_pkg.
module bwv_cordic_cell #(
   parameter int STAGE     = 0,
   parameter bit VECTORING = 1'b1,
   parameter int SIDE_W    = 1
) (
   input  logic                   clock,
   input  bwv_pkg::cordic_vec_type prev_vec,
   input  logic [SIDE_W-1:0]      prev_side,
   output bwv_pkg::cordic_vec_type next_vec,
   output logic [SIDE_W-1:0]      next_side
);
   import bwv_pkg::*;

   cordic_vec_type    vec_ff;
   cordic_vec_type    vec_in;
   logic [SIDE_W-1:0] side_ff;
   vec_type           vx;
   vec_type           vy;
   angle_type         vz;
   vec_type           x_sh;
   vec_type           y_sh;
   logic              add_ang;
   logic              rot_pos;

   always_comb begin
      vx   = prev_vec.x;
      vy   = prev_vec.y;
      vz   = prev_vec.z;
      x_sh = vx >>> STAGE;
      y_sh = vy >>> STAGE;
      if (VECTORING) begin
         add_ang = vy > vec_type'(0);
         rot_pos = !add_ang;
      end else begin
         rot_pos = vz >= angle_type'(0);
         add_ang = !rot_pos;
      end
      vec_in.x = rot_pos ? vx - y_sh : vx + y_sh;
      vec_in.y = rot_pos ? vy + x_sh : vy - x_sh;
      vec_in.z = add_ang ? vz + ATAN_Q40[STAGE] : vz - ATAN_Q40[STAGE];
   end

   always_ff @(posedge clock) begin
      vec_ff  <= vec_in;
      side_ff <= prev_side;
   end

   assign next_vec  = vec_ff;
   assign next_side = side_ff;

endmodule

// ----- src/bwv_div_cell.sv -----
// One restoring-division step for two dividers in lockstep, with a pass-along side word.
// Depends on bwv_pkg.
module bwv_div_cell #(
   parameter int SIDE_W = 1
) (
   input  logic                  clock,
   input  bwv_pkg::div_pair_type prev_pair,
   input  logic [SIDE_W-1:0]     prev_side,
   output bwv_pkg::div_pair_type next_pair,
   output logic [SIDE_W-1:0]     next_side
);
   import bwv_pkg::*;

   div_pair_type      pair_ff;
   div_pair_type      pair_in;
   logic [SIDE_W-1:0] side_ff;
   logic [DIV_W:0]    trial;
   logic              take;

   always_comb begin
      pair_in = prev_pair;
      trial   = '0;
      take    = 1'b0;
      for (int n = 0; n < 2; n++) begin
         trial = {prev_pair[n].rem, prev_pair[n].nlo[QUOT_BITS-1]};
         take  = trial >= {1'b0, prev_pair[n].dvs};
         pair_in[n].rem  = take ? DIV_W'(trial - {1'b0, prev_pair[n].dvs}) : DIV_W'(trial);
         pair_in[n].nlo  = prev_pair[n].nlo << 1;
         pair_in[n].quot = {prev_pair[n].quot[QUOT_BITS-2:0], take};
      end
   end

   always_ff @(posedge clock) begin
      pair_ff <= pair_in;
      side_ff <= prev_side;
   end

   assign next_pair = pair_ff;
   assign next_side = side_ff;

endmodule

// ----- src/breit_wigner_variate_transform_top.sv -----
// Breit-Wigner variate transform, top level: CORDIC chains, multipliers, divider chain.
// Depends on bwv_pkg, bwv_mul, bwv_cordic_cell, bwv_div_cell.
//
//   channel   ports                          handshake
//   request   req_uniform_sample             start, busy (always low)
//   response  rsp_mass_squared/jacobian/flag rsp_strobe, one cycle
//   config    csr_index, csr_write_data      csr_write_enable
//
// One sample per cycle; each result returns with rsp_strobe, in transfer order.
// Pipeline: the two CORDIC chains (one cell per stage), 66-cell divider, glue registers.
// Synchronous reset presets CSRs, clears the valid chain; in-flight samples are dropped.
// The receiver cannot stall; nothing inside ever waits.
module breit_wigner_variate_transform_top #(
   parameter int CORDIC_STAGES = 32,
   parameter int SAMPLE_BITS   = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_uniform_sample,
   output logic        rsp_strobe,
   output logic [47:0] rsp_mass_squared,
   output logic [47:0] rsp_jacobian_value,
   output logic        rsp_overflow_flag,
   input  logic        csr_write_enable,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_write_data
);
   import bwv_pkg::*;

   localparam int LATENCY = 2 * CORDIC_STAGES + PIPE_EXTRA;
   localparam int VSIDE_W = SAMPLE_BITS + 64;
   localparam int RSIDE_W = 192;
   localparam int TSIDE_W = $bits(tail_side_type);

   logic [31:0] mass_ff;
   logic [31:0] width_ff;
   logic        accept;
   logic        vld_ff [0:LATENCY-1];

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         mass_ff  <= MASS_RESET;
         width_ff <= WIDTH_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_PEAK_MASS:  mass_ff  <= csr_write_data;
            CSR_PEAK_WIDTH: width_ff <= csr_write_data;
            default:        mass_ff  <= mass_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LATENCY; k++) vld_ff[k] <= 1'b0;
      end else begin
         vld_ff[0] <= accept;
         for (int k = 1; k < LATENCY; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   // capture
   logic [SAMPLE_BITS-1:0] u0_ff;
   logic [31:0]            m0_ff;
   logic [31:0]            g0_ff;

   always_ff @(posedge clock) begin
      u0_ff <= SAMPLE_BITS'(req_uniform_sample);
      m0_ff <= mass_ff;
      g0_ff <= (width_ff == 32'd0) ? 32'd1 : width_ff;
   end

   // vectoring chain: atan(m/g)
   cordic_vec_type     vvec  [0:CORDIC_STAGES];
   logic [VSIDE_W-1:0] vside [0:CORDIC_STAGES];

   assign vvec[0]  = '{x: vec_type'({g0_ff, 24'd0}), y: vec_type'({m0_ff, 24'd0}), z: '0};
   assign vside[0] = {u0_ff, m0_ff, g0_ff};

   for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_vec
      bwv_cordic_cell #(.STAGE(s), .VECTORING(1'b1), .SIDE_W(VSIDE_W)) u_cell (
         .clock     (clock),
         .prev_vec  (vvec[s]),
         .prev_side (vside[s]),
         .next_vec  (vvec[s+1]),
         .next_side (vside[s+1])
      );
   end

   // clamp angle, form r
   angle_type              a_raw;
   angle_type              a_clamp;
   angle_type              ang_e1_ff;
   angle_type              ang_e2_ff;
   angle_type              ang_e3_ff;
   logic [RAD_W-1:0]       rad_e1_ff;
   logic [RAD_W-1:0]       rad_e2_ff;
   logic [RAD_W-1:0]       rad_e3_ff;
   logic [SAMPLE_BITS-1:0] u_e1_ff;
   logic [31:0]            m_e1_ff;
   logic [31:0]            g_e1_ff;

   always_comb begin
      a_raw = vvec[CORDIC_STAGES].z;
      if (a_raw < angle_type'(0))   a_clamp = '0;
      else if (a_raw > HALF_PI_Q40) a_clamp = HALF_PI_Q40;
      else                          a_clamp = a_raw;
   end

   always_ff @(posedge clock) begin
      ang_e1_ff <= a_clamp;
      rad_e1_ff <= RAD_W'(HALF_PI_Q40 + a_clamp);
      u_e1_ff   <= vside[CORDIC_STAGES][VSIDE_W-1:64];
      m_e1_ff   <= vside[CORDIC_STAGES][63:32];
      g_e1_ff   <= vside[CORDIC_STAGES][31:0];
      ang_e2_ff <= ang_e1_ff;
      ang_e3_ff <= ang_e2_ff;
      rad_e2_ff <= rad_e1_ff;
      rad_e3_ff <= rad_e2_ff;
   end

   logic [127:0] prod_ru;
   logic [127:0] prod_mg;
   logic [127:0] prod_mm;
   logic [127:0] prod_w;

   bwv_mul u_mul_ru (.clock(clock), .mul_a(64'(rad_e1_ff)), .mul_b(64'(u_e1_ff)),
                     .product(prod_ru));
   bwv_mul u_mul_mg (.clock(clock), .mul_a(64'(m_e1_ff)), .mul_b(64'(g_e1_ff)),
                     .product(prod_mg));
   bwv_mul u_mul_mm (.clock(clock), .mul_a(64'(m_e1_ff)), .mul_b(64'(m_e1_ff)),
                     .product(prod_mm));
   bwv_mul u_mul_w  (.clock(clock), .mul_a(64'(rad_e3_ff)), .mul_b(prod_mg[63:0]),
                     .product(prod_w));

   // target angle y
   logic [RAD_W-1:0] frac_e3;
   angle_type        z_e4_ff;
   angle_type        z_e5_ff;
   logic [63:0]      p_e4_ff;
   logic [63:0]      p_e5_ff;
   logic [63:0]      m2_e4_ff;
   logic [63:0]      m2_e5_ff;

   assign frac_e3 = RAD_W'(prod_ru >> SAMPLE_BITS);

   always_ff @(posedge clock) begin
      z_e4_ff  <= angle_type'(frac_e3) - ang_e3_ff;
      p_e4_ff  <= prod_mg[63:0];
      m2_e4_ff <= prod_mm[63:0];
      z_e5_ff  <= z_e4_ff;
      p_e5_ff  <= p_e4_ff;
      m2_e5_ff <= m2_e4_ff;
   end

   // rotation chain: cos(y), sin(y)
   cordic_vec_type     rvec  [0:CORDIC_STAGES];
   logic [RSIDE_W-1:0] rside [0:CORDIC_STAGES];

   assign rvec[0]  = '{x: ROT_X0, y: '0, z: z_e5_ff};
   assign rside[0] = {p_e5_ff, m2_e5_ff, prod_w[105:42]};

   for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_rot
      bwv_cordic_cell #(.STAGE(s), .VECTORING(1'b0), .SIDE_W(RSIDE_W)) u_cell (
         .clock     (clock),
         .prev_vec  (rvec[s]),
         .prev_side (rside[s]),
         .next_vec  (rvec[s+1]),
         .next_side (rside[s+1])
      );
   end

   // magnitudes and products for the dividers
   vec_type          cx;
   vec_type          cy;
   vec_type          ay_full;
   logic             pole_f1_ff, pole_f2_ff, pole_f3_ff;
   logic             neg_f1_ff, neg_f2_ff, neg_f3_ff;
   logic [MAG_W-1:0] ay_f1_ff;
   logic [MAG_W-1:0] cx_f1_ff, cx_f2_ff, cx_f3_ff;
   logic [63:0]      p_f1_ff;
   logic [63:0]      m2_f1_ff, m2_f2_ff, m2_f3_ff;
   logic [63:0]      w_f1_ff, w_f2_ff, w_f3_ff;

   assign cx      = rvec[CORDIC_STAGES].x;
   assign cy      = rvec[CORDIC_STAGES].y;
   assign ay_full = (cy < vec_type'(0)) ? -cy : cy;

   always_ff @(posedge clock) begin
      pole_f1_ff <= cx < POLE_LIMIT;
      neg_f1_ff  <= cy < vec_type'(0);
      ay_f1_ff   <= ay_full[MAG_W-1:0];
      cx_f1_ff   <= cx[MAG_W-1:0];
      p_f1_ff    <= rside[CORDIC_STAGES][191:128];
      m2_f1_ff   <= rside[CORDIC_STAGES][127:64];
      w_f1_ff    <= rside[CORDIC_STAGES][63:0];
      pole_f2_ff <= pole_f1_ff;
      pole_f3_ff <= pole_f2_ff;
      neg_f2_ff  <= neg_f1_ff;
      neg_f3_ff  <= neg_f2_ff;
      cx_f2_ff   <= cx_f1_ff;
      cx_f3_ff   <= cx_f2_ff;
      m2_f2_ff   <= m2_f1_ff;
      m2_f3_ff   <= m2_f2_ff;
      w_f2_ff    <= w_f1_ff;
      w_f3_ff    <= w_f2_ff;
   end

   logic [127:0] prod_pa;
   logic [127:0] prod_xx;
   logic [127:0] prod_yy;

   bwv_mul u_mul_pa (.clock(clock), .mul_a(p_f1_ff), .mul_b(64'(ay_f1_ff)),
                     .product(prod_pa));
   bwv_mul u_mul_xx (.clock(clock), .mul_a(64'(cx_f1_ff[MAG_W-1:12])),
                     .mul_b(64'(cx_f1_ff[MAG_W-1:12])), .product(prod_xx));
   bwv_mul u_mul_yy (.clock(clock), .mul_a(64'(ay_f1_ff[MAG_W-1:12])),
                     .mul_b(64'(ay_f1_ff[MAG_W-1:12])), .product(prod_yy));

   // divider setup
   logic [127:0]  num_sec;
   div_pair_type  pair_f4_ff;
   div_pair_type  pair_f4_in;
   tail_side_type side_f4_ff;
   tail_side_type side_f4_in;

   always_comb begin
      num_sec = (prod_xx + prod_yy) << 32;
      pair_f4_in[0].rem  = DIV_W'(prod_pa >> QUOT_BITS);
      pair_f4_in[0].dvs  = DIV_W'(cx_f3_ff);
      pair_f4_in[0].nlo  = prod_pa[QUOT_BITS-1:0];
      pair_f4_in[0].quot = '0;
      pair_f4_in[1].rem  = DIV_W'(num_sec >> QUOT_BITS);
      pair_f4_in[1].dvs  = DIV_W'(prod_xx);
      pair_f4_in[1].nlo  = num_sec[QUOT_BITS-1:0];
      pair_f4_in[1].quot = '0;
      side_f4_in.pole    = pole_f3_ff;
      side_f4_in.neg     = neg_f3_ff;
      side_f4_in.sat_tan = (prod_pa >> QUOT_BITS) >= 128'(cx_f3_ff);
      side_f4_in.sat_sec = (num_sec >> QUOT_BITS) >= prod_xx;
      side_f4_in.m2      = m2_f3_ff;
      side_f4_in.w       = w_f3_ff;
   end

   always_ff @(posedge clock) begin
      pair_f4_ff <= pair_f4_in;
      side_f4_ff <= side_f4_in;
   end

   div_pair_type       dpair [0:QUOT_BITS];
   logic [TSIDE_W-1:0] dside [0:QUOT_BITS];

   assign dpair[0] = pair_f4_ff;
   assign dside[0] = side_f4_ff;

   for (genvar s = 0; s < QUOT_BITS; s++) begin : g_div
      bwv_div_cell #(.SIDE_W(TSIDE_W)) u_cell (
         .clock     (clock),
         .prev_pair (dpair[s]),
         .prev_side (dside[s]),
         .next_pair (dpair[s+1]),
         .next_side (dside[s+1])
      );
   end

   // finish s, then jacobian
   tail_side_type        ts;
   logic [QUOT_BITS-1:0] q_tan;
   logic [QUOT_BITS-1:0] q_sec;
   logic [QUOT_BITS:0]   sum_g;
   logic [QUOT_BITS-16:0] sq_wide;
   logic [47:0]          sq_g;
   logic                 sqf_g;
   logic [127:0]         prod_j;

   logic [47:0] sq_g1_ff, sq_g2_ff;
   logic        sqf_g1_ff, sqf_g2_ff;
   logic        pole_g1_ff, pole_g2_ff;
   logic        secsat_g1_ff, secsat_g2_ff;
   logic        wz_g1_ff, wz_g2_ff;

   assign ts    = tail_side_type'(dside[QUOT_BITS]);
   assign q_tan = dpair[QUOT_BITS][0].quot;
   assign q_sec = dpair[QUOT_BITS][1].quot;

   always_comb begin
      sum_g   = '0;
      sq_wide = '0;
      sq_g    = '0;
      sqf_g   = 1'b0;
      if (ts.sat_tan) begin
         sq_g  = ts.neg ? 48'd0 : MAX48;
         sqf_g = !ts.neg;
      end else begin
         if (ts.neg) begin
            sum_g = (q_tan >= QUOT_BITS'(ts.m2)) ? '0
                  : (QUOT_BITS+1)'(ts.m2) - (QUOT_BITS+1)'(q_tan);
         end else begin
            sum_g = (QUOT_BITS+1)'(ts.m2) + (QUOT_BITS+1)'(q_tan);
         end
         sq_wide = sum_g[QUOT_BITS:16];
         if (sq_wide > (QUOT_BITS-15)'(MAX48)) begin
            sq_g  = MAX48;
            sqf_g = 1'b1;
         end else begin
            sq_g = sq_wide[47:0];
         end
      end
   end

   bwv_mul u_mul_j (.clock(clock), .mul_a(ts.w), .mul_b(q_sec[63:0]), .product(prod_j));

   always_ff @(posedge clock) begin
      sq_g1_ff     <= sq_g;
      sqf_g1_ff    <= sqf_g;
      pole_g1_ff   <= ts.pole;
      secsat_g1_ff <= ts.sat_sec || (q_sec[QUOT_BITS-1:64] != '0);
      wz_g1_ff     <= ts.w == 64'd0;
      sq_g2_ff     <= sq_g1_ff;
      sqf_g2_ff    <= sqf_g1_ff;
      pole_g2_ff   <= pole_g1_ff;
      secsat_g2_ff <= secsat_g1_ff;
      wz_g2_ff     <= wz_g1_ff;
   end

   logic [47:0] msq_ff, jac_ff, msq_in, jac_in;
   logic        flag_ff, flag_in;

   always_comb begin
      msq_in  = sq_g2_ff;
      jac_in  = '0;
      flag_in = sqf_g2_ff;
      if (pole_g2_ff) begin
         msq_in  = MAX48;
         jac_in  = MAX48;
         flag_in = 1'b1;
      end else if (wz_g2_ff) begin
         jac_in = '0;
      end else if (secsat_g2_ff || (prod_j[127:94] != '0)) begin
         jac_in  = MAX48;
         flag_in = 1'b1;
      end else begin
         jac_in = prod_j[93:46];
      end
   end

   always_ff @(posedge clock) begin
      msq_ff  <= msq_in;
      jac_ff  <= jac_in;
      flag_ff <= flag_in;
   end

   assign rsp_strobe         = vld_ff[LATENCY-1];
   assign rsp_mass_squared   = msq_ff;
   assign rsp_jacobian_value = jac_ff;
   assign rsp_overflow_flag  = flag_ff;

endmodule

// ----- src/bwv_checker.sv -----
// Port-level checks on the Breit-Wigner variate transform, bound to its top level.
// Depends on bwv_pkg.
module bwv_checker #(
   parameter int CORDIC_STAGES = 32
) (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_strobe
);
   import bwv_pkg::*;

   localparam int LATENCY = 2 * CORDIC_STAGES + PIPE_EXTRA;

   a_quiet_after_reset: assert property (@(posedge clock) $past(reset) |-> !rsp_strobe)
      else $error("result strobe right after reset");

   a_transfer_returns: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_strobe)
      else $error("accepted sample produced no result");

   a_result_has_source: assert property (@(posedge clock)
      rsp_strobe |-> $past(start && !busy, LATENCY))
      else $error("result without a matching transfer");

   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> !busy)
      else $error("busy raised while streaming");

endmodule

bind breit_wigner_variate_transform_top bwv_checker #(.CORDIC_STAGES(CORDIC_STAGES)) u_bwv_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe)
);

// ----- verif/tb_breit_wigner_variate_transform_top.sv -----
// Self-checking testbench for breit_wigner_variate_transform_top: directed table, then random bursts.
// Predicts s, jacobian and overflow flag of untyped transfers; depends on bwv_pkg and the top level.
`timescale 1ns / 1ps

module tb_breit_wigner_variate_transform_top;
   import bwv_pkg::*;

   localparam int STAGES  = 32;
   localparam int LATENCY = 2 * STAGES + 79;
   localparam logic [63:0] PI_60 = 64'h3243_F6A8_885A_308D;

   typedef struct {
      logic [47:0] mass_squared;
      logic [47:0] jacobian_value;
      logic        overflow_flag;
   } transform_result_type;

   typedef struct {
      logic [31:0]          mass;
      logic [31:0]          width;
      logic [31:0]          sample;
      logic                 typed;
      transform_result_type result;
   } directed_row_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [31:0] req_uniform_sample;
   logic        rsp_strobe;
   logic [47:0] rsp_mass_squared;
   logic [47:0] rsp_jacobian_value;
   logic        rsp_overflow_flag;
   logic        csr_write_enable;
   logic [0:0]  csr_index;
   logic [31:0] csr_write_data;

   longint               atan_angle [0:STAGES-1];
   logic [31:0]          cur_mass;
   logic [31:0]          cur_width;
   transform_result_type pending_results [$];
   transform_result_type typed_results [$];
   logic                 typed_flags [$];
   logic                 took;
   int                   mismatch_count;

   breit_wigner_variate_transform_top u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_uniform_sample(req_uniform_sample),
      .rsp_strobe(rsp_strobe), .rsp_mass_squared(rsp_mass_squared),
      .rsp_jacobian_value(rsp_jacobian_value), .rsp_overflow_flag(rsp_overflow_flag),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4ms;
      $display("status: fail");
      $finish;
   end

   function automatic longint atan_of_power(int i);
      longint sum;
      longint term;
      int     k;
      int     e;
      sum = 0;
      if (i == 0) begin
         sum = longint'(PI_60 >> 2);
      end else begin
         for (k = 0; k < 40; k++) begin
            e = i * (2 * k + 1);
            if (e <= 60) begin
               term = longint'(64'd1 << (60 - e)) / longint'(2 * k + 1);
               sum = (k % 2 == 1) ? sum - term : sum + term;
            end
         end
      end
      return (sum + 64'sd524288) >>> 20;
   endfunction

   function automatic transform_result_type predict_transform(logic [31:0] mass_in,
                                                              logic [31:0] width_in,
                                                              logic [31:0] sample);
      transform_result_type res;
      logic [63:0]  m;
      logic [63:0]  g;
      logic [63:0]  p;
      logic [63:0]  r;
      logic [63:0]  ay;
      logic [63:0]  m2;
      logic [63:0]  xs;
      logic [63:0]  ys;
      logic [63:0]  w;
      logic [127:0] prod;
      logic [127:0] q1;
      logic [127:0] sum;
      logic [127:0] den;
      logic [127:0] num;
      logic [127:0] sec;
      longint       half_pi;
      longint       vx;
      longint       vy;
      longint       a;
      longint       z;
      longint       cx;
      longint       cy;
      longint       nx;
      longint       ny;
      int           i;
      m = {32'd0, mass_in};
      g = (width_in == 32'd0) ? 64'd1 : {32'd0, width_in};
      half_pi = longint'((PI_60 + 64'd1048576) >> 21);
      vx = longint'(g << 24);
      vy = longint'(m << 24);
      a = 0;
      for (i = 0; i < STAGES; i++) begin
         if (vy > 0) begin
            nx = vx + (vy >>> i); ny = vy - (vx >>> i); a += atan_angle[i];
         end else begin
            nx = vx - (vy >>> i); ny = vy + (vx >>> i); a -= atan_angle[i];
         end
         vx = nx; vy = ny;
      end
      if (a < 0) a = 0;
      if (a > half_pi) a = half_pi;
      r = 64'(half_pi + a);
      prod = {64'd0, r} * {96'd0, sample};
      z = longint'(prod[95:32]) - a;
      cx = 64'sd1 << 57;
      cy = 0;
      for (i = 0; i < STAGES; i++) begin
         if (z >= 0) begin
            nx = cx - (cy >>> i); ny = cy + (cx >>> i); z -= atan_angle[i];
         end else begin
            nx = cx + (cy >>> i); ny = cy - (cx >>> i); z += atan_angle[i];
         end
         cx = nx; cy = ny;
      end
      if (cx < 4096) begin
         res.mass_squared = MAX48;
         res.jacobian_value = MAX48;
         res.overflow_flag = 1'b1;
         return res;
      end
      res.overflow_flag = 1'b0;
      p = m * g;
      ay = (cy < 0) ? 64'(-cy) : 64'(cy);
      q1 = ({64'd0, p} * {64'd0, ay}) / {64'd0, 64'(cx)};
      m2 = m * m;
      if (cy >= 0) sum = {64'd0, m2} + q1;
      else if (q1 >= {64'd0, m2}) sum = '0;
      else sum = {64'd0, m2} - q1;
      sum = sum >> 16;
      if (sum > {80'd0, MAX48}) begin
         res.mass_squared = MAX48; res.overflow_flag = 1'b1;
      end else begin
         res.mass_squared = sum[47:0];
      end
      xs = 64'(cx) >> 12;
      ys = ay >> 12;
      den = {64'd0, xs} * {64'd0, xs};
      num = (den + {64'd0, ys} * {64'd0, ys}) << 32;
      sec = num / den;
      prod = ({64'd0, r} * {64'd0, p}) >> 42;
      w = prod[63:0];
      if (w == 64'd0) begin
         res.jacobian_value = '0;
      end else if (sec[127:64] != 64'd0) begin
         res.jacobian_value = MAX48; res.overflow_flag = 1'b1;
      end else begin
         prod = ({64'd0, w} * {64'd0, sec[63:0]}) >> 46;
         if (prod > {80'd0, MAX48}) begin
            res.jacobian_value = MAX48; res.overflow_flag = 1'b1;
         end else begin
            res.jacobian_value = prod[47:0];
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
      mismatch_count++;
      $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
   endtask

   // record transfers and check results against the oldest expectation
   always @(posedge clock) begin
      transform_result_type want;
      logic                 typed;
      if (!reset && start && !busy) begin
         pending_results.push_back(predict_transform(cur_mass, cur_width, req_uniform_sample));
         took = 1'b1;
      end
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", rsp_mass_squared, '0);
         end else begin
            want = pending_results.pop_front();
            typed = typed_flags.pop_front();
            if (typed) want = typed_results.pop_front();
            if (rsp_mass_squared !== want.mass_squared)
               report_mismatch("mass_squared", rsp_mass_squared, want.mass_squared);
            if (rsp_jacobian_value !== want.jacobian_value)
               report_mismatch("jacobian_value", rsp_jacobian_value, want.jacobian_value);
            if (rsp_overflow_flag !== want.overflow_flag)
               report_mismatch("overflow_flag", {47'd0, rsp_overflow_flag},
                               {47'd0, want.overflow_flag});
         end
      end
   end

   task automatic wait_drained();
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   task automatic write_csr(logic [0:0] index, logic [31:0] value);
      csr_write_enable = 1'b1;
      csr_index = index;
      csr_write_data = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      if (index == CSR_PEAK_MASS) cur_mass = value;
      else cur_width = value;
   endtask

   task automatic set_peak(logic [31:0] mass, logic [31:0] width);
      wait_drained();
      write_csr(CSR_PEAK_MASS, mass);
      write_csr(CSR_PEAK_WIDTH, width);
   endtask

   // hold start for one transfer; drop it afterwards unless the burst goes on
   task automatic send_sample(logic [31:0] sample, logic typed, transform_result_type typed_res,
                              logic keep);
      start = 1'b1;
      req_uniform_sample = sample;
      typed_flags.push_back(typed);
      if (typed) typed_results.push_back(typed_res);
      took = 1'b0;
      do @(negedge clock); while (!took);
      took = 1'b0;
      if (!keep) start = 1'b0;
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom_range(1, 255);
         3: return $urandom_range(1, 32'h000F_FFFF);
         4: return $urandom_range(32'h0001_0000, 32'h0100_0000);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF - $urandom_range(0, 16);
         2: return $urandom_range(0, 16);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      directed_row_type     rows [$];
      directed_row_type     row;
      transform_result_type zero_res;
      logic [31:0]          samples [6];
      int                   i;
      int                   n;
      int                   phase;
      int                   burst;
      int                   gap;

      mismatch_count = 0;
      took = 1'b0;
      start = 1'b0;
      req_uniform_sample = '0;
      csr_write_enable = 1'b0;
      csr_index = CSR_PEAK_MASS;
      csr_write_data = '0;
      cur_mass = MASS_RESET;
      cur_width = WIDTH_RESET;
      for (i = 0; i < STAGES; i++) atan_angle[i] = atan_of_power(i);
      zero_res.mass_squared = '0;
      zero_res.jacobian_value = '0;
      zero_res.overflow_flag = 1'b0;

      samples = '{32'd0, 32'd1, 32'h8000_0000, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA};
      foreach (samples[k]) rows.push_back('{MASS_RESET, WIDTH_RESET, samples[k], 1'b0, zero_res});
      rows.push_back('{32'd0, WIDTH_RESET, 32'd0, 1'b1, zero_res});
      rows.push_back('{32'd0, WIDTH_RESET, 32'h8000_0000, 1'b1, zero_res});
      rows.push_back('{32'd0, WIDTH_RESET, 32'hFFFF_FFFF, 1'b0, zero_res});
      rows.push_back('{32'hFFFF_FFFF, 32'd0, 32'd0, 1'b0, zero_res});
      rows.push_back('{32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 1'b0, zero_res});
      rows.push_back('{32'hFFFF_FFFF, 32'd1, 32'h8000_0000, 1'b0, zero_res});
      rows.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1'b0, zero_res});
      rows.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, zero_res});
      rows.push_back('{32'd1, 32'hFFFF_FFFF, 32'd0, 1'b0, zero_res});
      rows.push_back('{32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, zero_res});
      rows.push_back('{32'd1, 32'd1, 32'h4000_0000, 1'b0, zero_res});
      rows.push_back('{32'h0001_0000, 32'h0100_0000, 32'd7, 1'b0, zero_res});
      rows.push_back('{32'h0001_0000, 32'h0100_0000, 32'hFFFF_FFF0, 1'b0, zero_res});
      rows.push_back('{32'h0100_0000, 32'd1, 32'hFFFF_FFFF, 1'b0, zero_res});

      reset = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (rows[k]) begin
         row = rows[k];
         if (row.mass != cur_mass || row.width != cur_width) set_peak(row.mass, row.width);
         send_sample(row.sample, row.typed, row.result, 1'b0);
      end

      for (phase = 0; phase < 10; phase++) begin
         case (phase)
            0: set_peak(MASS_RESET, WIDTH_RESET);
            1: set_peak(32'hFFFF_FFFF, 32'hFFFF_FFFF);
            2: set_peak(32'd0, 32'd1);
            3: set_peak(32'hFFFF_FFFF, 32'd0);
            default: set_peak(pick_value(), pick_value());
         endcase
         n = 0;
         while (n < 125) begin
            burst = $urandom_range(1, 24);
            for (i = 0; i < burst && n < 125; i++) begin
               send_sample(pick_sample(), 1'b0, zero_res, i + 1 < burst && n + 1 < 125);
               n++;
            end
            start = 1'b0;
            gap = (phase % 3 == 0) ? 0 : $urandom_range(0, 12);
            repeat (gap) @(negedge clock);
         end
         if (phase == 5) wait_drained();
      end

      start = 1'b0;
      wait_drained();
      repeat (LATENCY + 20) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ----- files.f -----
src/bwv_pkg.sv
src/bwv_mul.sv
src/bwv_cordic_cell.sv
src/bwv_div_cell.sv
src/breit_wigner_variate_transform_top.sv
src/bwv_checker.sv
verif/tb_breit_wigner_variate_transform_top.sv
